### hdl/udp_ipv4_frame_builder_top_assert.svh
// Assertion macros shared by the frame builder modules.
`ifndef UDP_IPV4_FRAME_BUILDER_TOP_ASSERT_SVH
`define UDP_IPV4_FRAME_BUILDER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define UFB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ufb assertion failed");

// Next-cycle implication, checked out of reset.
`define UFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ufb assertion failed");

`endif

### hdl/ufb_pkg.sv
// Types and constants of the UDP/IPv4 frame builder.
`timescale 1ns / 1ps
`default_nettype none

package ufb_pkg;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  IP_VER_IHL     = 8'h45;
    localparam logic [7:0]  IP_TOS         = 8'h00;
    localparam logic [15:0] IP_TOTAL_LEN   = 16'd36;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [15:0] UDP_TOTAL_LEN  = 16'd16;
    localparam logic [15:0] CSUM_ZERO_SUB  = 16'hFFFF;

    localparam logic [15:0] RST_UDP_SRC_PORT = 16'd6000;
    localparam logic [15:0] RST_UDP_DST_PORT = 16'd6666;
    localparam logic [7:0]  RST_TTL          = 8'd64;

    localparam logic [2:0] LAST_BEAT  = 3'd6;
    localparam logic [3:0] BYTES_FULL = 4'd8;
    localparam logic [3:0] BYTES_TAIL = 4'd2;

    typedef enum logic [2:0] {
        CFG_DEST_MAC   = 3'd0,
        CFG_SOURCE_MAC = 3'd1,
        CFG_SOURCE_IP  = 3'd2,
        CFG_DEST_IP    = 3'd3,
        CFG_UDP_SPORT  = 3'd4,
        CFG_UDP_DPORT  = 3'd5,
        CFG_TTL        = 3'd6
    } t_cfg_idx;

    // Header fields the user keeps fixed while frames are built; the block does not enforce it.
    typedef struct packed {
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] udp_sport;
        logic [15:0] udp_dport;
        logic [7:0]  ttl;
        logic [15:0] ip_csum;
    } t_hdr_cfg;

endpackage

`default_nettype wire

### hdl/ufb_front.sv
// Front end: accepts send timestamps into a small request queue.
`timescale 1ns / 1ps
`default_nettype none

`include "udp_ipv4_frame_builder_top_assert.svh"

module ufb_front #(
    parameter int DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [63:0] i_send_time,
    output logic             o_q_valid,
    input  wire logic        i_q_ready,
    output logic [63:0]      o_q_time
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [63:0]   r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          wr_en;
    logic          rd_en;

    assign full      = (r_cnt == CW'(DEPTH));
    assign o_q_valid = (r_cnt != '0);
    assign o_q_time  = r_mem[r_rd];
    assign wr_en     = push && !full;
    assign rd_en     = o_q_valid && i_q_ready;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (wr_en) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (rd_en) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({wr_en, rd_en})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_send_time;
        end
    end

    `UFB_ASSERT_NEXT(a_cnt_up, i_clk, i_rst_n, wr_en && !rd_en, r_cnt == $past(r_cnt) + 1'b1)
    `UFB_ASSERT_IMPLY(a_ptr_gap, i_clk, i_rst_n, r_cnt == '0, r_wr == r_rd)

endmodule

`default_nettype wire

### hdl/ufb_back.sv
// Back end: walks the seven beats of a frame into the output register.
`timescale 1ns / 1ps
`default_nettype none

`include "udp_ipv4_frame_builder_top_assert.svh"

module ufb_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ufb_pkg::t_hdr_cfg i_cfg,
    input  wire logic              i_q_valid,
    output logic                   o_q_ready,
    input  wire logic [63:0]       i_q_time,
    output logic                   empty,
    input  wire logic              pop,
    output logic [63:0]            o_frame_word,
    output logic [3:0]             o_valid_bytes,
    output logic                   o_last_beat
);

    logic        r_busy, n_busy;
    logic [2:0]  r_beat, n_beat;
    logic [63:0] r_time;
    logic        r_out_valid, n_out_valid;
    logic [63:0] r_word;
    logic [3:0]  r_vb;
    logic        r_last;

    logic        advance;
    logic        last_adv;
    logic        load;
    logic [63:0] beat_word;
    logic [63:0] t;

    assign advance   = r_busy && (!r_out_valid || pop);
    assign last_adv  = advance && (r_beat == ufb_pkg::LAST_BEAT);
    assign o_q_ready = !r_busy || last_adv;
    assign load      = i_q_valid && o_q_ready;
    assign t         = r_time;

    always_comb begin
        unique case (r_beat)
            3'd0: beat_word = {i_cfg.dest_mac, i_cfg.source_mac[47:32]};
            3'd1: beat_word = {i_cfg.source_mac[31:0], ufb_pkg::ETHERTYPE_IPV4,
                               ufb_pkg::IP_VER_IHL, ufb_pkg::IP_TOS};
            3'd2: beat_word = {ufb_pkg::IP_TOTAL_LEN, 16'h0000, 16'h0000,
                               i_cfg.ttl, ufb_pkg::PROTO_UDP};
            3'd3: beat_word = {i_cfg.ip_csum, i_cfg.source_ip, i_cfg.dest_ip[31:16]};
            3'd4: beat_word = {i_cfg.dest_ip[15:0], i_cfg.udp_sport, i_cfg.udp_dport,
                               ufb_pkg::UDP_TOTAL_LEN};
            // payload goes out least significant byte first
            3'd5: beat_word = {16'h0000, t[7:0], t[15:8], t[23:16], t[31:24],
                               t[39:32], t[47:40]};
            3'd6: beat_word = {t[55:48], t[63:56], 48'h0};
            default: beat_word = '0;
        endcase
    end

    always_comb begin
        n_busy      = r_busy;
        n_beat      = r_beat;
        n_out_valid = r_out_valid;
        if (advance) begin
            n_beat      = r_beat + 1'b1;
            n_out_valid = 1'b1;
        end else if (pop) begin
            n_out_valid = 1'b0;
        end
        if (last_adv) begin
            n_busy = 1'b0;
        end
        // take the next timestamp in the same cycle the last beat leaves
        if (load) begin
            n_busy = 1'b1;
            n_beat = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_beat      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_beat      <= n_beat;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_time <= i_q_time;
        end
        if (advance) begin
            r_word <= beat_word;
            r_vb   <= (r_beat == ufb_pkg::LAST_BEAT) ? ufb_pkg::BYTES_TAIL
                                                     : ufb_pkg::BYTES_FULL;
            r_last <= (r_beat == ufb_pkg::LAST_BEAT);
        end
    end

    assign empty         = !r_out_valid;
    assign o_frame_word  = r_word;
    assign o_valid_bytes = r_vb;
    assign o_last_beat   = r_last;

    `UFB_ASSERT_IMPLY(a_tail_bytes, i_clk, i_rst_n, r_out_valid && r_last, r_vb == ufb_pkg::BYTES_TAIL)
    `UFB_ASSERT_IMPLY(a_beat_range, i_clk, i_rst_n, r_busy, r_beat <= ufb_pkg::LAST_BEAT)
    `UFB_ASSERT_NEXT(a_frame_done, i_clk, i_rst_n, last_adv && !i_q_valid, !r_busy && r_last)

endmodule

`default_nettype wire

### hdl/udp_ipv4_frame_builder_top.sv
// Top level of the UDP/IPv4 frame builder: configuration, checksum, front and back.
//
//  Channel   Handshake                      Payload
//  request   push / full                    i_send_time
//  frame     empty / pop                    o_frame_word, o_valid_bytes, o_last_beat
//  config    i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// Each request yields seven beats, one per cycle while pop keeps up, and frames follow
// each other without a gap. A taken request passes the queue memory and the back end's
// time register before its first beat is registered into the output word.
// Reset is synchronous and active low; it empties the queue and loads register defaults.
// pop low holds the output register and stalls the back end; the request queue then
// fills and full rises. Configuration writes are always taken.
`timescale 1ns / 1ps
`default_nettype none

module udp_ipv4_frame_builder_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [63:0] i_send_time,
    output logic             empty,
    input  wire logic        pop,
    output logic [63:0]      o_frame_word,
    output logic [3:0]       o_valid_bytes,
    output logic             o_last_beat,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);

    logic [47:0] r_dest_mac;
    logic [47:0] r_source_mac;
    logic [31:0] r_source_ip;
    logic [31:0] r_dest_ip;
    logic [15:0] r_udp_sport;
    logic [15:0] r_udp_dport;
    logic [7:0]  r_ttl;
    logic [15:0] r_csum;
    logic [15:0] n_csum;

    logic [19:0] sum;
    logic [16:0] fold1;
    logic [16:0] fold2;
    logic [15:0] inv;

    ufb_pkg::t_hdr_cfg hdr_cfg;

    logic        q_valid;
    logic        q_ready;
    logic [63:0] q_time;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_mac   <= '0;
            r_source_mac <= '0;
            r_source_ip  <= '0;
            r_dest_ip    <= '0;
            r_udp_sport  <= ufb_pkg::RST_UDP_SRC_PORT;
            r_udp_dport  <= ufb_pkg::RST_UDP_DST_PORT;
            r_ttl        <= ufb_pkg::RST_TTL;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (ufb_pkg::t_cfg_idx'(i_cfg_index))
                ufb_pkg::CFG_DEST_MAC:   r_dest_mac   <= i_cfg_data[47:0];
                ufb_pkg::CFG_SOURCE_MAC: r_source_mac <= i_cfg_data[47:0];
                ufb_pkg::CFG_SOURCE_IP:  r_source_ip  <= i_cfg_data[31:0];
                ufb_pkg::CFG_DEST_IP:    r_dest_ip    <= i_cfg_data[31:0];
                ufb_pkg::CFG_UDP_SPORT:  r_udp_sport  <= i_cfg_data[15:0];
                ufb_pkg::CFG_UDP_DPORT:  r_udp_dport  <= i_cfg_data[15:0];
                ufb_pkg::CFG_TTL:        r_ttl        <= i_cfg_data[7:0];
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    // IPv4 header checksum; only the registers vary, the rest are constant words
    always_comb begin
        sum = 20'({ufb_pkg::IP_VER_IHL, ufb_pkg::IP_TOS})
            + 20'(ufb_pkg::IP_TOTAL_LEN)
            + 20'({r_ttl, ufb_pkg::PROTO_UDP})
            + 20'(r_source_ip[31:16]) + 20'(r_source_ip[15:0])
            + 20'(r_dest_ip[31:16])   + 20'(r_dest_ip[15:0]);
        fold1  = 17'(sum[19:16]) + 17'(sum[15:0]);
        fold2  = 17'(fold1[16]) + 17'(fold1[15:0]);
        inv    = ~fold2[15:0];
        n_csum = (inv == 16'h0000) ? ufb_pkg::CSUM_ZERO_SUB : inv;
    end

    always_ff @(posedge i_clk) begin
        r_csum <= n_csum;
    end

    always_comb begin
        hdr_cfg.dest_mac   = r_dest_mac;
        hdr_cfg.source_mac = r_source_mac;
        hdr_cfg.source_ip  = r_source_ip;
        hdr_cfg.dest_ip    = r_dest_ip;
        hdr_cfg.udp_sport  = r_udp_sport;
        hdr_cfg.udp_dport  = r_udp_dport;
        hdr_cfg.ttl        = r_ttl;
        hdr_cfg.ip_csum    = r_csum;
    end

    ufb_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_send_time (i_send_time),
        .o_q_valid   (q_valid),
        .i_q_ready   (q_ready),
        .o_q_time    (q_time)
    );

    ufb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (hdr_cfg),
        .i_q_valid     (q_valid),
        .o_q_ready     (q_ready),
        .i_q_time      (q_time),
        .empty         (empty),
        .pop           (pop),
        .o_frame_word  (o_frame_word),
        .o_valid_bytes (o_valid_bytes),
        .o_last_beat   (o_last_beat)
    );

endmodule

`default_nettype wire

### bench/udp_ipv4_frame_builder_top_tb.sv
// Self-checking testbench for the UDP/IPv4 frame builder: register setups, frames, backpressure.
`timescale 1ns / 1ps

module udp_ipv4_frame_builder_top_tb;

    localparam logic [15:0] ETH_TYPE_IP   = 16'h0800;
    localparam logic [15:0] IP_VER_TOS    = 16'h4500;
    localparam logic [15:0] IP_LEN        = 16'd36;
    localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
    localparam logic [15:0] UDP_LEN       = 16'd16;
    localparam int          FRAME_LEN     = 50;
    localparam int          BEATS         = 7;
    localparam logic [2:0]  CFG_NO_REG    = 3'd7;
    localparam int          DRAIN_CYCLES  = 12;
    localparam int          HOLDOFF_LEN   = 300;
    localparam int          RANDOM_PHASES = 6;
    localparam int          PHASE_ITEMS   = 42;

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        last;
    } t_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic [63:0] i_send_time = '0;
    logic        pop = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;
    logic        full;
    logic        empty;
    logic [63:0] o_frame_word;
    logic [3:0]  o_valid_bytes;
    logic        o_last_beat;
    logic        o_cfg_ready;

    udp_ipv4_frame_builder_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_send_time   (i_send_time),
        .empty         (empty),
        .pop           (pop),
        .o_frame_word  (o_frame_word),
        .o_valid_bytes (o_valid_bytes),
        .o_last_beat   (o_last_beat),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Shadow copy of the header registers.
    logic [47:0] cur_dest_mac   = '0;
    logic [47:0] cur_source_mac = '0;
    logic [31:0] cur_source_ip  = '0;
    logic [31:0] cur_dest_ip    = '0;
    logic [15:0] cur_udp_sport  = 16'd6000;
    logic [15:0] cur_udp_dport  = 16'd6666;
    logic [7:0]  cur_ttl        = 8'd64;

    logic [63:0] send_queue[$];
    t_beat       frame_beat_q[$];

    int errors       = 0;
    int frames_sent  = 0;
    int beats_seen   = 0;
    int full_stalls  = 0;
    int reg_writes   = 0;
    int settings     = 1;
    int burst_left   = 0;
    int gap_left     = 0;
    int stall_mode   = 0;
    int stall_run    = 0;
    int stall_tick   = 0;
    int hold_cnt     = 0;
    logic hold_arm   = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [15:0] ip_checksum(input logic [7:0] ttl,
                                                input logic [31:0] sip,
                                                input logic [31:0] dip);
        logic [31:0] acc;
        acc = 32'(IP_VER_TOS) + 32'(IP_LEN) + 32'({ttl, IP_PROTO_UDP})
            + 32'(sip[31:16]) + 32'(sip[15:0]) + 32'(dip[31:16]) + 32'(dip[15:0]);
        acc = (acc >> 16) + (acc & 32'hFFFF);
        acc = (acc >> 16) + (acc & 32'hFFFF);
        acc = ~acc & 32'hFFFF;
        return (acc == 32'd0) ? 16'hFFFF : acc[15:0];
    endfunction

    // Build the whole frame and queue its seven beats.
    function automatic void predict_frame(input logic [63:0] stamp);
        logic [0:55][7:0] fb;
        t_beat            b;
        int               nb;
        fb = '0;
        fb[0:5]   = cur_dest_mac;
        fb[6:11]  = cur_source_mac;
        fb[12:13] = ETH_TYPE_IP;
        fb[14:15] = IP_VER_TOS;
        fb[16:17] = IP_LEN;
        fb[22]    = cur_ttl;
        fb[23]    = IP_PROTO_UDP;
        fb[24:25] = ip_checksum(cur_ttl, cur_source_ip, cur_dest_ip);
        fb[26:29] = cur_source_ip;
        fb[30:33] = cur_dest_ip;
        fb[34:35] = cur_udp_sport;
        fb[36:37] = cur_udp_dport;
        fb[38:39] = UDP_LEN;
        for (int i = 0; i < 8; i++)
            fb[42 + i] = stamp[8 * i +: 8];
        for (int k = 0; k < BEATS; k++) begin
            nb       = FRAME_LEN - 8 * k;
            b.word   = fb[8 * k +: 8];
            b.nbytes = (nb > 8) ? 4'd8 : 4'(nb);
            b.last   = (k == BEATS - 1);
            frame_beat_q.push_back(b);
        end
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [63:0] value);
        case (idx)
            ufb_pkg::CFG_DEST_MAC:   cur_dest_mac   = value[47:0];
            ufb_pkg::CFG_SOURCE_MAC: cur_source_mac = value[47:0];
            ufb_pkg::CFG_SOURCE_IP:  cur_source_ip  = value[31:0];
            ufb_pkg::CFG_DEST_IP:    cur_dest_ip    = value[31:0];
            ufb_pkg::CFG_UDP_SPORT:  cur_udp_sport  = value[15:0];
            ufb_pkg::CFG_UDP_DPORT:  cur_udp_dport  = value[15:0];
            ufb_pkg::CFG_TTL:        cur_ttl        = value[7:0];
            default: ;
        endcase
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 64'd0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic log_fault(input string what, input t_beat exp_b, input t_beat got_b);
        errors++;
        if (errors <= 10)
            $display({"%s at beat %0d: expected word %h bytes %0d last %0b, ",
                      "got word %h bytes %0d last %0b"},
                     what, beats_seen, exp_b.word, exp_b.nbytes, exp_b.last,
                     got_b.word, got_b.nbytes, got_b.last);
    endtask

    // Request driver: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                predict_frame(send_queue.pop_front());
                frames_sent++;
            end
            if (push && full) begin
                // hold the offered transaction
                full_stalls++;
            end else if (gap_left != 0) begin
                gap_left--;
                push <= 1'b0;
            end else if (send_queue.size() != 0) begin
                push        <= 1'b1;
                i_send_time <= send_queue[0];
                if (burst_left == 0)
                    burst_left = $urandom_range(1, 24);
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20)
                                                           : $urandom_range(0, 2);
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, started by a one-cycle arm pulse.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            hold_cnt <= 0;
        else if (hold_arm)
            hold_cnt <= HOLDOFF_LEN;
        else if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
    end

    // Frame monitor: check each popped beat, then pick the next pop.
    always @(posedge i_clk) begin
        t_beat got_b;
        t_beat exp_b;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                got_b = '{o_frame_word, o_valid_bytes, o_last_beat};
                if (frame_beat_q.size() == 0) begin
                    log_fault("Unexpected beat", '0, got_b);
                end else begin
                    exp_b = frame_beat_q.pop_front();
                    if (got_b.word !== exp_b.word || got_b.nbytes !== exp_b.nbytes ||
                        got_b.last !== exp_b.last)
                        log_fault("Mismatch", exp_b, got_b);
                end
                beats_seen++;
            end
            if (stall_run == 0) begin
                stall_mode = $urandom_range(0, 2);
                stall_run  = $urandom_range(20, 80);
            end
            stall_run--;
            stall_tick = (stall_tick == 2) ? 0 : stall_tick + 1;
            if (hold_cnt != 0)
                pop <= 1'b0;
            else if (stall_mode == 0)
                pop <= 1'b1;
            else if (stall_mode == 1)
                pop <= ($urandom_range(0, 99) >= 35);
            else
                pop <= (stall_tick != 0);
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, value);
        reg_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_frames_drained();
        @(negedge i_clk);
        while (send_queue.size() != 0 || push || frame_beat_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic random_setup();
        cfg_write(ufb_pkg::CFG_DEST_MAC,   rand_word());
        cfg_write(ufb_pkg::CFG_SOURCE_MAC, rand_word());
        cfg_write(ufb_pkg::CFG_SOURCE_IP,  rand_word());
        cfg_write(ufb_pkg::CFG_DEST_IP,    rand_word());
        cfg_write(ufb_pkg::CFG_UDP_SPORT,  rand_word());
        cfg_write(ufb_pkg::CFG_UDP_DPORT,  rand_word());
        cfg_write(ufb_pkg::CFG_TTL,        rand_word());
        cfg_write(CFG_NO_REG,              rand_word());
        settings++;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Register defaults, payload extremes and single bits.
        @(negedge i_clk);
        send_queue.push_back(64'd0);
        send_queue.push_back('1);
        send_queue.push_back(64'h0123_4567_89AB_CDEF);
        send_queue.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        send_queue.push_back(64'h5555_5555_5555_5555);
        send_queue.push_back(64'h0000_0000_0000_0001);
        send_queue.push_back(64'h8000_0000_0000_0000);
        wait_frames_drained();

        // Every register at its maximum, written with all data bits set.
        cfg_write(ufb_pkg::CFG_DEST_MAC,   '1);
        cfg_write(ufb_pkg::CFG_SOURCE_MAC, '1);
        cfg_write(ufb_pkg::CFG_SOURCE_IP,  '1);
        cfg_write(ufb_pkg::CFG_DEST_IP,    '1);
        cfg_write(ufb_pkg::CFG_UDP_SPORT,  '1);
        cfg_write(ufb_pkg::CFG_UDP_DPORT,  '1);
        cfg_write(ufb_pkg::CFG_TTL,        '1);
        cfg_write(CFG_NO_REG,              64'h0123_4567_89AB_CDEF);
        settings++;
        @(negedge i_clk);
        repeat (3) send_queue.push_back({$urandom, $urandom});
        wait_frames_drained();

        // Header sum folds to all ones, so the checksum must read 0xFFFF.
        cfg_write(ufb_pkg::CFG_DEST_MAC,   64'hFFFF_0000_0000_0000);
        cfg_write(ufb_pkg::CFG_SOURCE_MAC, 64'h1234_0000_0000_0000);
        cfg_write(ufb_pkg::CFG_SOURCE_IP,  64'h5A5A_5A5A_BACA_0000);
        cfg_write(ufb_pkg::CFG_DEST_IP,    64'hDEAD_BEEF_0000_0000);
        cfg_write(ufb_pkg::CFG_UDP_SPORT,  64'hFFFF_FFFF_FFFF_0000);
        cfg_write(ufb_pkg::CFG_UDP_DPORT,  64'd0);
        cfg_write(ufb_pkg::CFG_TTL,        64'hFF00);
        settings++;
        @(negedge i_clk);
        send_queue.push_back(64'd0);
        send_queue.push_back('1);
        send_queue.push_back(64'hFEDC_BA98_7654_3210);
        wait_frames_drained();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            random_setup();
            @(negedge i_clk);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_queue.push_back(rand_word());
            if (p == 1) begin
                // stall the receiver while requests keep coming
                hold_arm = 1'b1;
                @(negedge i_clk);
                hold_arm = 1'b0;
            end
            wait_frames_drained();
        end

        $display("Built %0d frames (%0d beats checked) under %0d header setups,",
                 frames_sent, beats_seen, settings);
        $display("%0d register writes; requests waited on a full queue for %0d cycles.",
                 reg_writes, full_stalls);
        if (errors == 0 && frame_beat_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
